// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, control codes and controller/datapath types for the
// text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // default screen geometry
    localparam int DEFAULT_COLS = 80;
    localparam int DEFAULT_ROWS = 25;

    // field widths of the item and result words
    localparam int OP_W         = 1;
    localparam int CHAR_W       = 8;
    localparam int READ_ROW_W   = 5;
    localparam int READ_COL_W   = 7;
    localparam int COLOR_W      = 8;
    localparam int CELL_W       = CHAR_W + COLOR_W;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_LO = 2;
    localparam logic [APB_ADDR_W-1:REG_IDX_LO] REG_TEXT_COLOR = 1'b0;

    // operations
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // cell contents
    localparam logic [CHAR_W-1:0]  BLANK_CHAR    = 8'h20;
    localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'h0F;
    localparam int                 TAB_STEP      = 8;

    // control codes
    localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd127;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_ACCESS,
        ST_BLANK,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic calc_addr;
        logic access;
        logic sweep_wr;
        logic clear;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scroll;
        logic sweep_last_col;
        logic sweep_last_row;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hdl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: item words in, result
// words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_item_if import tcw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [CHAR_W-1:0]       char_code;
    logic [READ_ROW_W-1:0]   read_row;
    logic [READ_COL_W-1:0]   read_col;

    modport source (output valid, output operation, output char_code,
                    output read_row, output read_col, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input read_row, input read_col, output ready);
endinterface

interface tcw_result_if import tcw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CHAR_W-1:0]       cell_char;
    logic [COLOR_W-1:0]      cell_color;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic [CURSOR_COL_W-1:0] cursor_col;

    modport source (output valid, output cell_char, output cell_color,
                    output cursor_row, output cursor_col, input ready);
    modport sink   (input valid, input cell_char, input cell_color,
                    input cursor_row, input cursor_col, output ready);
endinterface

`default_nettype wire

// File: hdl/tcw_regs.sv
// ----------------------------------------------------------------------------
// tcw_regs
// Configuration register file: holds the text colour, written and read
// over the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_regs import tcw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [COLOR_W-1:0]    o_text_color
);

    logic               w_sel_color;
    logic [COLOR_W-1:0] r_text_color;

    // register decode on the word index
    assign w_sel_color = (paddr[APB_ADDR_W-1:REG_IDX_LO] == REG_TEXT_COLOR);

    // text colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= DEFAULT_COLOR;
        end else if (psel && penable && pwrite && w_sel_color) begin
            r_text_color <= pwdata[COLOR_W-1:0];
        end
    end

    // read back, no wait states
    assign prdata       = w_sel_color ? APB_DATA_W'(r_text_color) : '0;
    assign pready       = 1'b1;
    assign o_text_color = r_text_color;

endmodule

`default_nettype wire

// File: hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console writer: reset clear sweep, per-word
// address/access/result steps and the row blanking sweep of a scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.sweep_last_col && i_sts.sweep_last_row) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_state = ST_ACCESS;
            end
            ST_ACCESS: begin
                n_state = i_sts.scroll ? ST_BLANK : ST_DONE;
            end
            ST_BLANK: begin
                if (i_sts.sweep_last_col) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                o_cmd.clear    = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_ADDR: begin
                o_cmd.calc_addr = 1'b1;
            end
            ST_ACCESS: begin
                o_cmd.access = 1'b1;
            end
            ST_BLANK: begin
                o_cmd.sweep_wr = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory as a ring of rows, cursor and scroll pointer, sweep
// counters and the result register of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
    parameter int ROWS = DEFAULT_ROWS,
    parameter int COLS = DEFAULT_COLS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_sts                      o_sts,
    input  wire logic [OP_W-1:0]         i_operation,
    input  wire logic [CHAR_W-1:0]       i_char_code,
    input  wire logic [READ_ROW_W-1:0]   i_read_row,
    input  wire logic [READ_COL_W-1:0]   i_read_col,
    input  wire logic [COLOR_W-1:0]      i_text_color,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic      [CHAR_W-1:0]       o_cell_char,
    output logic      [COLOR_W-1:0]      o_cell_color,
    output logic      [CURSOR_ROW_W-1:0] o_cursor_row,
    output logic      [CURSOR_COL_W-1:0] o_cursor_col
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);

    // captured word
    logic [OP_W-1:0]       r_op;
    logic [CHAR_W-1:0]     r_char;
    logic [READ_ROW_W-1:0] r_rrow;
    logic [READ_COL_W-1:0] r_rcol;

    // address step
    logic             r_rd_ok;
    logic [ROW_W-1:0] r_prow;
    logic [COL_W-1:0] r_pcol;

    // cursor, ring top and sweep position
    logic [ROW_W-1:0] r_cur_row;
    logic [COL_W-1:0] r_cur_col;
    logic [ROW_W-1:0] r_top;
    logic [ROW_W-1:0] r_sw_row;
    logic [COL_W-1:0] r_sw_col;
    logic [ROW_W-1:0] n_cur_row;
    logic [COL_W-1:0] n_cur_col;

    // memory and result
    logic [CELL_W-1:0]       r_mem [CELLS];
    logic [CELL_W-1:0]       r_mem_q;
    logic                    r_out_valid;
    logic [CHAR_W-1:0]       r_out_char;
    logic [COLOR_W-1:0]      r_out_color;
    logic [CURSOR_ROW_W-1:0] r_out_row;
    logic [CURSOR_COL_W-1:0] r_out_col;

    // combinational
    logic [31:0]      w_rrow_ext;
    logic [31:0]      w_rcol_ext;
    logic [31:0]      w_crow_ext;
    logic [31:0]      w_ccol_ext;
    logic             w_is_read;
    logic             w_rd_ok;
    logic [ROW_W-1:0] w_row_sel;
    logic [COL_W-1:0] w_col_sel;
    logic [ROW_W:0]   w_row_sum;
    logic [ROW_W:0]   w_row_wrap;
    logic [COL_W:0]   w_col_inc;
    logic [COL_W:0]   w_col_tab;
    logic             w_is_print;
    logic             w_wrap;
    logic             w_scroll;
    logic [ROW_W-1:0] w_mem_row;
    logic [COL_W-1:0] w_mem_col;
    logic [AW-1:0]    w_mem_addr;
    logic             w_mem_we;
    logic [CELL_W-1:0] w_mem_wdata;
    logic             w_out_free;

    // read coordinates, range check and physical row in the ring
    assign w_is_read  = (r_op == OP_READ);
    assign w_rrow_ext = 32'(r_rrow);
    assign w_rcol_ext = 32'(r_rcol);
    assign w_rd_ok    = w_is_read && (w_rrow_ext < 32'(ROWS)) && (w_rcol_ext < 32'(COLS));
    assign w_row_sel  = w_is_read ? w_rrow_ext[ROW_W-1:0] : r_cur_row;
    assign w_col_sel  = w_is_read ? w_rcol_ext[COL_W-1:0] : r_cur_col;
    assign w_row_sum  = {1'b0, w_row_sel} + {1'b0, r_top};
    assign w_row_wrap = (w_row_sum >= (ROW_W+1)'(ROWS)) ?
                        (w_row_sum - (ROW_W+1)'(ROWS)) : w_row_sum;

    // cursor stepping for a put word
    assign w_col_inc  = {1'b0, r_cur_col} + (COL_W+1)'(1);
    assign w_col_tab  = ({1'b0, r_cur_col} + (COL_W+1)'(TAB_STEP))
                        & ~((COL_W+1)'(TAB_STEP - 1));
    assign w_is_print = (r_char >= CH_PRINT_LO) && (r_char <= CH_PRINT_HI);

    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        w_wrap    = 1'b0;
        case (r_char) inside
            CH_LF: begin
                w_wrap = 1'b1;
            end
            CH_CR: begin
                n_cur_col = '0;
            end
            CH_TAB: begin
                n_cur_col = w_col_tab[COL_W-1:0];
                w_wrap    = (w_col_tab >= (COL_W+1)'(COLS));
            end
            CH_BS: begin
                if (r_cur_col != '0) begin
                    n_cur_col = r_cur_col - COL_W'(1);
                end
            end
            [CH_PRINT_LO:CH_PRINT_HI]: begin
                n_cur_col = w_col_inc[COL_W-1:0];
                w_wrap    = (w_col_inc >= (COL_W+1)'(COLS));
            end
            default: begin
                n_cur_col = r_cur_col;
            end
        endcase
        // row end or newline: next row, bottom row stays put and scrolls
        if (w_wrap) begin
            n_cur_col = '0;
            if (r_cur_row != ROW_W'(ROWS - 1)) begin
                n_cur_row = r_cur_row + ROW_W'(1);
            end
        end
    end

    assign w_scroll = !w_is_read && w_wrap && (r_cur_row == ROW_W'(ROWS - 1));

    // shared memory address: sweep position or the word's cell
    assign w_mem_row  = i_cmd.sweep_wr ? r_sw_row : r_prow;
    assign w_mem_col  = i_cmd.sweep_wr ? r_sw_col : r_pcol;
    assign w_mem_addr = AW'(w_mem_row) * AW'(COLS) + AW'(w_mem_col);
    assign w_mem_we   = i_cmd.sweep_wr || (i_cmd.access && !w_is_read && w_is_print);

    always_comb begin
        if (i_cmd.sweep_wr) begin
            w_mem_wdata = {(i_cmd.clear ? DEFAULT_COLOR : i_text_color), BLANK_CHAR};
        end else begin
            w_mem_wdata = {i_text_color, r_char};
        end
    end

    // screen memory, one write or one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (i_cmd.access && r_rd_ok) begin
            r_mem_q <= r_mem[w_mem_addr];
        end
    end

    // word capture and address step
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        if (i_cmd.calc_addr) begin
            r_rd_ok <= w_rd_ok;
            r_prow  <= w_row_wrap[ROW_W-1:0];
            r_pcol  <= w_col_sel;
        end
    end

    // cursor, ring top and sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_top     <= '0;
            r_sw_row  <= '0;
            r_sw_col  <= '0;
        end else begin
            if (i_cmd.access && !w_is_read) begin
                r_cur_row <= n_cur_row;
                r_cur_col <= n_cur_col;
                if (w_scroll) begin
                    // the old top row becomes the new bottom row
                    r_top    <= (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
                    r_sw_row <= r_top;
                    r_sw_col <= '0;
                end
            end
            if (i_cmd.sweep_wr) begin
                if (r_sw_col == COL_W'(COLS - 1)) begin
                    r_sw_col <= '0;
                    if (i_cmd.clear) begin
                        r_sw_row <= (r_sw_row == ROW_W'(ROWS - 1)) ? '0 :
                                    r_sw_row + ROW_W'(1);
                    end
                end else begin
                    r_sw_col <= r_sw_col + COL_W'(1);
                end
            end
        end
    end

    // result register
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_crow_ext = 32'(r_cur_row);
    assign w_ccol_ext = 32'(r_cur_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_char  <= r_rd_ok ? r_mem_q[CHAR_W-1:0] : '0;
            r_out_color <= r_rd_ok ? r_mem_q[CELL_W-1:CHAR_W] : '0;
            r_out_row   <= w_crow_ext[CURSOR_ROW_W-1:0];
            r_out_col   <= w_ccol_ext[CURSOR_COL_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_color = r_out_color;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

    // status to the controller
    assign o_sts.scroll         = w_scroll;
    assign o_sts.sweep_last_col = (r_sw_col == COL_W'(COLS - 1));
    assign o_sts.sweep_last_row = (r_sw_row == ROW_W'(ROWS - 1));
    assign o_sts.out_free       = w_out_free;

    // cursor and ring top stay on the screen
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_row) < 32'(ROWS)) && (32'(r_cur_col) < 32'(COLS)))
        else $error("cursor left the screen");

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_top) < 32'(ROWS))
        else $error("ring top out of range");

    // a read word never moves the cursor
    a_read_keeps_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.access && w_is_read) |=> ($stable(r_cur_row) && $stable(r_cur_col)))
        else $error("read moved the cursor");

    // a scroll parks the cursor at column 0 of the bottom row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.access && w_scroll) |=>
            ((r_cur_row == ROW_W'(ROWS - 1)) && (r_cur_col == '0)))
        else $error("cursor wrong after scroll");

endmodule

`default_nettype wire

// File: hdl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console: interprets put words as characters or control codes on a
// ROWS x COLS screen with a cursor, and answers cell read words.
//
//   channel    dir  protocol     payload
//   i_item     in   valid/ready  operation, char_code, read_row, read_col
//   o_result   out  valid/ready  cell_char, cell_color, cursor_row, cursor_col
//   apb        in   APB write    text_color at byte address 0
//
// A word passes through capture in the accepting cycle, ring row address,
// memory access and result load into the output register.
// A put that scrolls adds a blanking step: the vacated row is blanked one
// cell per cycle through the single memory write port.
// After reset the screen memory is cleared cell by cell with i_item.ready
// low; APB writes are taken throughout.
// A word is accepted while a previous result still waits in the output
// register; a stalled result holds the next word at its result step.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top import tcw_pkg::*; #(
    parameter int ROWS = DEFAULT_ROWS,
    parameter int COLS = DEFAULT_COLS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tcw_item_if.sink                   i_item,
    tcw_result_if.source               o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic               w_in_ready;
    logic [COLOR_W-1:0] w_text_color;
    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;

    // configuration registers
    tcw_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_text_color (w_text_color)
    );

    // sequencer
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_item.ready = w_in_ready;

    // screen, cursor and result register
    tcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_operation  (i_item.operation),
        .i_char_code  (i_item.char_code),
        .i_read_row   (i_item.read_row),
        .i_read_col   (i_item.read_col),
        .i_text_color (w_text_color),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_cell_char  (o_result.cell_char),
        .o_cell_color (o_result.cell_color),
        .o_cursor_row (o_result.cursor_row),
        .o_cursor_col (o_result.cursor_col)
    );

endmodule

`default_nettype wire

// File: bench/tcw_console_check.sv
// ----------------------------------------------------------------------------
// tcw_console_check
// Passive checker for the text console writer. It follows the item, result
// and APB traffic, keeps its own copy of the screen, the cursor and the text
// colour, predicts the result word of every accepted item and compares each
// accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tcw_console_check import tcw_pkg::*; #(
    parameter int ROWS = DEFAULT_ROWS,
    parameter int COLS = DEFAULT_COLS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tcw_item_if                        mon_item,
    tcw_result_if                      mon_result,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = ROWS * COLS;

    typedef struct packed {
        logic [CHAR_W-1:0]       cell_char;
        logic [COLOR_W-1:0]      cell_color;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
    } t_console_reply;

    // mirrored console state
    logic [CELL_W-1:0]  screen [CELLS];
    int unsigned        crow;
    int unsigned        ccol;
    logic [COLOR_W-1:0] ink;

    t_console_reply awaited_replies[$];
    int             fails = 0;

    assign o_fail_count = fails;

    // cursor to column 0 of the next row, scrolling off the bottom
    function void line_feed();
        ccol = 0;
        crow++;
        if (crow >= ROWS) begin
            for (int i = 0; i + COLS < CELLS; i++)
                screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen[i] = {ink, BLANK_CHAR};
            crow = ROWS - 1;
        end
    endfunction

    // control code or printable byte at the cursor
    function void apply_put(logic [CHAR_W-1:0] ch);
        if (ch == CH_LF) begin
            line_feed();
        end else if (ch == CH_CR) begin
            ccol = 0;
        end else if (ch == CH_TAB) begin
            ccol = ((ccol + TAB_STEP) / TAB_STEP) * TAB_STEP;
            if (ccol >= COLS)
                line_feed();
        end else if (ch == CH_BS) begin
            if (ccol > 0)
                ccol--;
        end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
            screen[crow * COLS + ccol] = {ink, ch};
            ccol++;
            if (ccol >= COLS)
                line_feed();
        end
    endfunction

    // result word of one item, updating the mirror for a put
    function t_console_reply predict_reply(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                           logic [READ_ROW_W-1:0] rr,
                                           logic [READ_COL_W-1:0] rc);
        t_console_reply r;
        logic [CELL_W-1:0] entry;
        r = '0;
        if (op == OP_PUT) begin
            apply_put(ch);
        end else if (rr < ROWS && rc < COLS) begin
            entry = screen[rr * COLS + rc];
            r.cell_char  = entry[CHAR_W-1:0];
            r.cell_color = entry[CELL_W-1:CHAR_W];
        end
        r.cursor_row = CURSOR_ROW_W'(crow);
        r.cursor_col = CURSOR_COL_W'(ccol);
        return r;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fails++;
        end
    endfunction

    // monitor: config writes, result words, then newly accepted item words
    always @(posedge i_clk) begin
        t_console_reply got;
        t_console_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = {DEFAULT_COLOR, BLANK_CHAR};
            crow = 0;
            ccol = 0;
            ink  = DEFAULT_COLOR;
            awaited_replies.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_ADDR_W-1:REG_IDX_LO] == REG_TEXT_COLOR)
                ink = i_pwdata[COLOR_W-1:0];

            if (mon_result.valid && mon_result.ready) begin
                got.cell_char  = mon_result.cell_char;
                got.cell_color = mon_result.cell_color;
                got.cursor_row = mon_result.cursor_row;
                got.cursor_col = mon_result.cursor_col;
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, got);
                    fails++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("cell_char", want.cell_char, got.cell_char);
                    compare_field("cell_color", want.cell_color, got.cell_color);
                    compare_field("cursor_row", want.cursor_row, got.cursor_row);
                    compare_field("cursor_col", want.cursor_col, got.cursor_col);
                end
            end

            if (mon_item.valid && mon_item.ready)
                awaited_replies.push_back(predict_reply(mon_item.operation,
                    mon_item.char_code, mon_item.read_row, mon_item.read_col));
        end
        o_pending <= awaited_replies.size();
    end

endmodule

// File: bench/text_console_writer_top_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Stimulus and verdict for the text console writer. A short directed run
// covers control codes, ignored bytes, field extremes and out-of-range reads,
// then phases of random words at several text colours, with random gaps and
// stalls on both channels and one long result stall, are checked by
// tcw_console_check.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb import tcw_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS            = DEFAULT_ROWS;
    localparam int COLS            = DEFAULT_COLS;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 240;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AFTER      = 600;
    localparam int SETTLE_CYCLES   = 120;
    localparam logic [APB_ADDR_W-1:REG_IDX_LO] REG_UNMAPPED = 1'b1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;
    int                    phase_no = 0;
    int                    results_rx = 0;

    tcw_item_if   item_ch ();
    tcw_result_if result_ch ();

    text_console_writer_top #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tcw_console_check #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .mon_item    (item_ch),
        .mon_result  (result_ch),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready)
            results_rx++;
    end

    function automatic logic [APB_ADDR_W-1:0] reg_addr(logic [APB_ADDR_W-1:REG_IDX_LO] idx);
        return APB_ADDR_W'(idx) << REG_IDX_LO;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len(bit calm);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55)
            return 0;
        else if (pick < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [READ_ROW_W-1:0] rand_row();
        if ($urandom_range(0, 99) < 85)
            return READ_ROW_W'($urandom_range(0, ROWS - 1));
        return READ_ROW_W'($urandom_range(ROWS, 2**READ_ROW_W - 1));
    endfunction

    function automatic logic [READ_COL_W-1:0] rand_col();
        if ($urandom_range(0, 99) < 85)
            return READ_COL_W'($urandom_range(0, COLS - 1));
        return READ_COL_W'($urandom_range(COLS, 2**READ_COL_W - 1));
    endfunction

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // offer one item word and hold it until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [READ_ROW_W-1:0] rr,
                             input logic [READ_COL_W-1:0] rc);
        @(negedge i_clk);
        item_ch.valid     = 1'b1;
        item_ch.operation = op;
        item_ch.char_code = ch;
        item_ch.read_row  = rr;
        item_ch.read_col  = rc;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // valid low for the gap given by n, junk on the payload
    task automatic idle_item(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            item_ch.valid     = 1'b0;
            item_ch.operation = OP_W'($urandom_range(0, 1));
            item_ch.char_code = CHAR_W'($urandom_range(0, 255));
            item_ch.read_row  = READ_ROW_W'($urandom_range(0, 2**READ_ROW_W - 1));
            item_ch.read_col  = READ_COL_W'($urandom_range(0, 2**READ_COL_W - 1));
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, READ_ROW_W'($urandom_range(0, 2**READ_ROW_W - 1)),
                  READ_COL_W'($urandom_range(0, 2**READ_COL_W - 1)));
        idle_item(gap_len(phase_no % 3 == 2));
    endtask

    task automatic read_cell(input logic [READ_ROW_W-1:0] rr,
                             input logic [READ_COL_W-1:0] rc);
        send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), rr, rc);
        idle_item(gap_len(phase_no % 3 == 2));
    endtask

    // even phases: short lines, many scrolls; odd phases: long lines, row wraps
    task automatic send_random();
        int unsigned pick;
        int unsigned lf_floor;
        logic [CHAR_W-1:0] ch;
        lf_floor = (phase_no % 2 == 0) ? 80 : 99;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            read_cell(rand_row(), rand_col());
        end else begin
            pick = $urandom_range(0, 99);
            if (pick >= lf_floor) begin
                ch = CH_LF;
            end else if (pick < 10) begin
                ch = CH_TAB;
            end else if (pick < 14 && lf_floor < 99) begin
                ch = CH_CR;
            end else if (pick < 22 && pick >= 14) begin
                ch = CH_BS;
            end else if (pick < 27 && pick >= 22) begin
                do ch = CHAR_W'($urandom_range(0, CH_PRINT_LO - 1));
                while (ch == CH_BS || ch == CH_TAB || ch == CH_LF || ch == CH_CR);
            end else if (pick < 32 && pick >= 27) begin
                ch = CHAR_W'($urandom_range(CH_PRINT_HI + 1, 255));
            end else begin
                ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
            end
            put_char(ch);
        end
    endtask

    // result side: random stalls, calm stretches, one long hold-off
    initial begin
        int  hold_left;
        bit  long_done;
        int unsigned pick;
        hold_left = 0;
        long_done = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready = 1'b0;
                hold_left--;
            end else if (!long_done && results_rx >= HOLD_AFTER) begin
                result_ch.ready = 1'b0;
                hold_left = LONG_HOLD - 1;
                long_done = 1'b1;
            end else if (phase_no % 3 == 1) begin
                result_ch.ready = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    result_ch.ready = 1'b1;
                end else begin
                    result_ch.ready = 1'b0;
                    hold_left = (pick < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [COLOR_W-1:0]    colour;
        logic [APB_DATA_W-1:0] data;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_ch.valid     = 1'b0;
        item_ch.operation = OP_PUT;
        item_ch.char_code = '0;
        item_ch.read_row  = '0;
        item_ch.read_col  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset screen, read extremes and out-of-range cells
        read_cell('0, '0);
        read_cell(READ_ROW_W'(ROWS - 1), READ_COL_W'(COLS - 1));
        read_cell(READ_ROW_W'(ROWS), '0);
        read_cell('0, READ_COL_W'(COLS));
        read_cell('1, '1);
        // printable extremes, ignored bytes, control codes
        put_char(8'd65);
        put_char(CH_PRINT_LO);
        put_char(CH_PRINT_HI);
        put_char(8'd0);
        put_char(CHAR_W'(CH_PRINT_LO - 1));
        put_char(CHAR_W'(CH_PRINT_HI + 1));
        put_char(8'd255);
        put_char(CH_BS);
        put_char(CH_CR);
        put_char(CH_BS);
        put_char(CH_TAB);
        put_char(CH_TAB);
        put_char(CH_LF);
        put_char(8'd122);
        // read back what was written
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd2);
        read_cell(5'd1, 7'd0);
        read_cell(5'd0, 7'd3);

        for (int p = 0; p < PHASES; p++) begin
            @(negedge i_clk);
            item_ch.valid = 1'b0;
            wait (pending == 0);
            phase_no = p;
            case (p)
                0:       colour = 8'h00;
                1:       colour = 8'hFF;
                2:       colour = 8'hA5;
                4:       colour = 8'h80;
                default: colour = COLOR_W'($urandom_range(0, 255));
            endcase
            data = $urandom;
            data[COLOR_W-1:0] = colour;
            apb_write(reg_addr(REG_TEXT_COLOR), data);
            // a write beyond the register list must leave the colour alone
            if (p == 2)
                apb_write(reg_addr(REG_UNMAPPED), $urandom);
            repeat (WORDS_PER_PHASE) send_random();
        end

        @(negedge i_clk);
        item_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: text_console_writer_top.f
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_regs.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer_top.sv
bench/tcw_console_check.sv
bench/text_console_writer_top_tb.sv
